### rtl/core/sorted_key_table_binary_search_defines.svh
// Assertion macros used by the checker of the sorted key table.
`ifndef SORTED_KEY_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_KEY_TABLE_BINARY_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SKT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted key table check failed");

// Next-cycle implication, disabled while reset is high.
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted key table check failed");

`endif

### rtl/core/skt_pkg.sv
// Package with widths, codes and cell interface types of the sorted key table.
`timescale 1ns / 1ps
`default_nettype none
package skt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 128;

   localparam int KIND_W    = 2;
   localparam int KEY_W     = 27;
   localparam int PAYLOAD_W = 64;
   localparam int STATUS_W  = 3;
   localparam int POS_W     = 8;
   localparam int COUNT_W   = 8;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 3'd0,
      ST_DUP   = 3'd1,
      ST_FULL  = 3'd2,
      ST_BLANK = 3'd3,
      ST_MISS  = 3'd4
   } status_type;

   typedef struct packed {
      logic search;
      logic insert;
      logic remove;
   } cell_ctrl_type;

   typedef struct packed {
      logic lt;
      logic eq;
      logic at_pos;
   } cell_flags_type;

endpackage
`default_nettype wire

### rtl/core/skt_cell.sv
// One table cell: holds a key and payload, compares and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module skt_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire skt_pkg::cell_ctrl_type          ctrl,
   input  wire logic                            occupied,
   input  wire logic [skt_pkg::KEY_W-1:0]       new_key,
   input  wire logic [skt_pkg::PAYLOAD_W-1:0]   new_payload,
   input  wire logic                            left_lt,
   input  wire logic [skt_pkg::KEY_W-1:0]       left_key,
   input  wire logic [skt_pkg::PAYLOAD_W-1:0]   left_payload,
   input  wire logic [skt_pkg::KEY_W-1:0]       right_key,
   input  wire logic [skt_pkg::PAYLOAD_W-1:0]   right_payload,
   output logic [skt_pkg::KEY_W-1:0]            key_ff,
   output logic [skt_pkg::PAYLOAD_W-1:0]        payload_ff,
   output skt_pkg::cell_flags_type              flags
);

   logic lt_ff;
   logic eq_ff;

   // The lower-than flags form a thermometer, so the insertion point is where it ends.
   assign flags.lt     = lt_ff;
   assign flags.eq     = eq_ff;
   assign flags.at_pos = left_lt & ~lt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else if (ctrl.search) begin
         lt_ff <= occupied & (key_ff < new_key);
         eq_ff <= occupied & (key_ff == new_key);
      end
   end

   // Cells at or above the search position move; those below keep their entry.
   always_ff @(posedge clock) begin
      if (ctrl.insert && !lt_ff) begin
         if (flags.at_pos) begin
            key_ff     <= new_key;
            payload_ff <= new_payload;
         end else begin
            key_ff     <= left_key;
            payload_ff <= left_payload;
         end
      end else if (ctrl.remove && !lt_ff) begin
         key_ff     <= right_key;
         payload_ff <= right_payload;
      end
   end

endmodule
`default_nettype wire

### rtl/core/sorted_key_table_binary_search.sv
// Top level of the sorted key table: request capture, control and a row of cells.
//
//   channel   direction  handshake            payload
//   request   in         start / busy         req_kind, req_key, req_record_payload,
//                                             req_record_blank
//   response  out        rsp_valid (strobe)   rsp_status, rsp_found, rsp_position,
//                                             rsp_payload_out, rsp_entry_count
//
// An item passes through three steps: capture, a compare step in which every cell checks its
// key, and an update step that resolves the position and shifts the row of cells.
// The response strobe is high for one cycle after the update, with busy already low,
// so a new item can be started in that same cycle.
// Synchronous reset empties the table; the cell contents are not cleared.
// The response cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_table_binary_search #(
   parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [skt_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [skt_pkg::KEY_W-1:0]       req_key,
   input  wire logic [skt_pkg::PAYLOAD_W-1:0]   req_record_payload,
   input  wire logic                            req_record_blank,
   output logic                                 rsp_valid,
   output logic [skt_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                 rsp_found,
   output logic [skt_pkg::POS_W-1:0]            rsp_position,
   output logic [skt_pkg::PAYLOAD_W-1:0]        rsp_payload_out,
   output logic [skt_pkg::COUNT_W-1:0]          rsp_entry_count
);

   localparam int IDX_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_UPDATE = 3'b100
   } state_type;

   state_type                         state_ff, state_in;
   logic [IDX_W-1:0]                  count_ff, count_in;
   logic [skt_pkg::KIND_W-1:0]        kind_ff;
   logic [skt_pkg::KEY_W-1:0]         key_ff;
   logic [skt_pkg::PAYLOAD_W-1:0]     payload_ff;
   logic                              blank_ff;

   logic [skt_pkg::KEY_W-1:0]         cell_key     [TABLE_DEPTH];
   logic [skt_pkg::PAYLOAD_W-1:0]     cell_payload [TABLE_DEPTH];
   skt_pkg::cell_flags_type           cell_flags   [TABLE_DEPTH];
   skt_pkg::cell_ctrl_type            ctrl;

   logic                              hit;
   logic [skt_pkg::PAYLOAD_W-1:0]     hit_payload;
   logic [IDX_W-1:0]                  pos_enc;
   logic [IDX_W-1:0]                  position;
   logic                              full;
   logic                              do_insert;
   logic                              do_remove;
   skt_pkg::status_type               status;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (start) state_in = S_SEARCH;
         S_SEARCH: state_in = S_UPDATE;
         S_UPDATE: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         kind_ff    <= req_kind;
         key_ff     <= req_key;
         payload_ff <= req_record_payload;
         blank_ff   <= req_record_blank;
      end
   end

   // Reduce the registered cell flags: at most one cell matches, at most one marks the position.
   always_comb begin
      hit         = 1'b0;
      hit_payload = '0;
      pos_enc     = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit         = hit | cell_flags[i].eq;
         hit_payload = hit_payload | (cell_flags[i].eq ? cell_payload[i] : '0);
         pos_enc     = pos_enc | (cell_flags[i].at_pos ? IDX_W'(i) : '0);
      end
   end

   // When every cell holds a smaller key, the key would go past the last entry.
   assign position = cell_flags[TABLE_DEPTH-1].lt ? IDX_W'(TABLE_DEPTH) : pos_enc;
   assign full     = (count_ff == IDX_W'(TABLE_DEPTH));

   always_comb begin
      do_insert = 1'b0;
      do_remove = 1'b0;
      case (kind_ff)
         skt_pkg::KIND_INSERT: begin
            if (blank_ff)  status = skt_pkg::ST_BLANK;
            else if (full) status = skt_pkg::ST_FULL;
            else if (hit)  status = skt_pkg::ST_DUP;
            else begin
               status    = skt_pkg::ST_DONE;
               do_insert = (state_ff == S_UPDATE);
            end
         end
         skt_pkg::KIND_REMOVE: begin
            if (hit) begin
               status    = skt_pkg::ST_DONE;
               do_remove = (state_ff == S_UPDATE);
            end else begin
               status = skt_pkg::ST_MISS;
            end
         end
         default: status = hit ? skt_pkg::ST_DONE : skt_pkg::ST_MISS;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert)      count_in = count_ff + 1'b1;
      else if (do_remove) count_in = count_ff - 1'b1;
   end

   assign ctrl.search = (state_ff == S_SEARCH);
   assign ctrl.insert = do_insert;
   assign ctrl.remove = do_remove;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == S_UPDATE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_UPDATE) begin
         rsp_status      <= status;
         rsp_found       <= hit;
         rsp_position    <= skt_pkg::POS_W'(position);
         rsp_payload_out <= (kind_ff != skt_pkg::KIND_INSERT &&
                             kind_ff != skt_pkg::KIND_REMOVE && hit) ? hit_payload : '0;
         rsp_entry_count <= skt_pkg::COUNT_W'(count_in);
      end
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic                              left_lt;
      logic [skt_pkg::KEY_W-1:0]         left_key;
      logic [skt_pkg::PAYLOAD_W-1:0]     left_payload;
      logic [skt_pkg::KEY_W-1:0]         right_key;
      logic [skt_pkg::PAYLOAD_W-1:0]     right_payload;
      logic                              occupied;

      assign occupied = (IDX_W'(g) < count_ff);

      if (g == 0) begin : g_first
         assign left_lt      = 1'b1;
         assign left_key     = key_ff;
         assign left_payload = payload_ff;
      end else begin : g_inner_left
         assign left_lt      = cell_flags[g-1].lt;
         assign left_key     = cell_key[g-1];
         assign left_payload = cell_payload[g-1];
      end

      if (g == TABLE_DEPTH - 1) begin : g_last
         assign right_key     = cell_key[g];
         assign right_payload = cell_payload[g];
      end else begin : g_inner_right
         assign right_key     = cell_key[g+1];
         assign right_payload = cell_payload[g+1];
      end

      skt_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .occupied      (occupied),
         .new_key       (key_ff),
         .new_payload   (payload_ff),
         .left_lt       (left_lt),
         .left_key      (left_key),
         .left_payload  (left_payload),
         .right_key     (right_key),
         .right_payload (right_payload),
         .key_ff        (cell_key[g]),
         .payload_ff    (cell_payload[g]),
         .flags         (cell_flags[g])
      );
   end

endmodule
`default_nettype wire

### rtl/core/skt_checker.sv
// Port-level checker of the sorted key table and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_table_binary_search_defines.svh"
module skt_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            start,
   input wire logic                            busy,
   input wire logic [skt_pkg::KIND_W-1:0]      req_kind,
   input wire logic [skt_pkg::KEY_W-1:0]       req_key,
   input wire logic [skt_pkg::PAYLOAD_W-1:0]   req_record_payload,
   input wire logic                            req_record_blank,
   input wire logic                            rsp_valid,
   input wire logic [skt_pkg::STATUS_W-1:0]    rsp_status,
   input wire logic                            rsp_found,
   input wire logic [skt_pkg::POS_W-1:0]       rsp_position,
   input wire logic [skt_pkg::PAYLOAD_W-1:0]   rsp_payload_out,
   input wire logic [skt_pkg::COUNT_W-1:0]     rsp_entry_count
);

   logic unused_inputs;
   assign unused_inputs = ^{req_kind, req_key, req_record_payload, req_record_blank,
                            rsp_position, rsp_entry_count};

   // An accepted item holds busy high through the search and update states, then is answered with busy low.
   `SKT_ASSERT_NEXT(a_item_latency, clock, reset, start && !busy,
                    busy ##1 busy ##1 (rsp_valid && !busy))

   // Strobes are single-cycle pulses.
   `SKT_ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_valid, !rsp_valid)

   // A key that was present is never reported as missing.
   `SKT_ASSERT_NOW(a_found_not_miss, clock, reset, rsp_valid && rsp_found,
                   rsp_status != skt_pkg::ST_MISS)

   // Nonzero payload only comes from a successful hit.
   `SKT_ASSERT_NOW(a_payload_hit, clock, reset, rsp_valid && (rsp_payload_out != '0),
                   rsp_found && (rsp_status == skt_pkg::ST_DONE))

endmodule

bind sorted_key_table_binary_search skt_checker u_skt_checker (.*);
`default_nettype wire
